>>> rtl/lef_pkg.sv
// ----------------------------------------------------------------------------
// lef_pkg
// Shared constants and types of the 3x3 Laplacian edge filter.
// ----------------------------------------------------------------------------
package lef_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int SIZE_W = 11;   // frame size register width
  localparam int POS_W  = 10;   // column / row field width on the output

  // compare width that holds counters, sizes and a +1 without overflow
  localparam int CNT_W  = (COL_W > ROW_W) ? COL_W : ROW_W;
  localparam int CMP_W  = ((CNT_W > SIZE_W) ? CNT_W : SIZE_W) + 1;

  localparam int CHAN_W = 8;
  localparam int NCHAN  = 3;

  // element 0 is red, 1 green, 2 blue
  typedef logic [NCHAN-1:0][CHAN_W-1:0] pixel_t;

  // 3x3 window of one channel, row-major, center at index 4
  typedef logic [8:0][CHAN_W-1:0] lane_win_t;

  // line store access for one transfer
  typedef struct packed {
    logic             rd_en;     // read both lines, write new pixel to line 1
    logic [COL_W-1:0] rd_addr;
    logic             wr0_en;    // move previous line-1 data into line 0
    logic [COL_W-1:0] wr0_addr;
  } ls_ctrl_t;

endpackage

>>> rtl/lef_line_store.sv
// ----------------------------------------------------------------------------
// lef_line_store
// Two line memories holding the previous two rows of the frame.
// ----------------------------------------------------------------------------
module lef_line_store
  import lef_pkg::*;
(
  input  logic     clk_i,
  input  ls_ctrl_t ctrl_i,
  input  pixel_t   px_i,
  output pixel_t   top_o,
  output pixel_t   mid_o
);

  pixel_t line0_mem [MAX_WIDTH];
  pixel_t line1_mem [MAX_WIDTH];
  pixel_t top_q;
  pixel_t mid_q;

  // line 1 is read-first: the read returns the row above, then takes the new pixel
  always_ff @(posedge clk_i) begin
    if (ctrl_i.rd_en) begin
      mid_q                     <= line1_mem[ctrl_i.rd_addr];
      line1_mem[ctrl_i.rd_addr] <= px_i;
    end
  end

  // line 0 gets the old line-1 entry one stage later; forward on a same-column hit
  always_ff @(posedge clk_i) begin
    if (ctrl_i.rd_en) begin
      if (ctrl_i.wr0_en && (ctrl_i.wr0_addr == ctrl_i.rd_addr)) begin
        top_q <= mid_q;
      end else begin
        top_q <= line0_mem[ctrl_i.rd_addr];
      end
    end
    if (ctrl_i.wr0_en) begin
      line0_mem[ctrl_i.wr0_addr] <= mid_q;
    end
  end

  assign top_o = top_q;
  assign mid_o = mid_q;

endmodule

>>> rtl/lef_lane.sv
// ----------------------------------------------------------------------------
// lef_lane
// Laplacian of one color channel: 8*center minus the eight neighbors,
// clamped to 0..255.
// ----------------------------------------------------------------------------
module lef_lane
  import lef_pkg::*;
(
  input  lane_win_t         win_i,
  output logic [CHAN_W-1:0] edge_o
);

  localparam int SUM_W = CHAN_W + 3;

  logic        [SUM_W-1:0] nb_sum;
  logic signed [SUM_W:0]   lap;

  always_comb begin
    nb_sum = '0;
    for (int i = 0; i < 9; i++) begin
      if (i != 4) begin
        nb_sum = nb_sum + SUM_W'(win_i[i]);
      end
    end
  end

  assign lap = $signed({1'b0, win_i[4], 3'b000}) - $signed({1'b0, nb_sum});

  always_comb begin
    if (lap < 0) begin
      edge_o = '0;
    end else if (lap > $signed((SUM_W+1)'(255))) begin
      edge_o = '1;
    end else begin
      edge_o = lap[CHAN_W-1:0];
    end
  end

endmodule

>>> rtl/laplacian_edge_filter_3x3_unit.sv
// ----------------------------------------------------------------------------
// laplacian_edge_filter_3x3_unit
// Streaming 3x3 Laplacian edge filter over RGB frames, one lane per channel.
// ----------------------------------------------------------------------------
//  Channel   Dir  Payload                                        Marker
//  s_axis    in   tdata: red, green, blue                        tuser: 1 = flush
//  m_axis    out  tdata: red, green, blue, column, row           tlast: frame end
//  apb       in   0x0 frame_width, 0x4 frame_height (11 bits)    -
//
//  One transfer per clock in and out. A pixel is accepted into a stage that
//  reads both line memories; the next stage shifts the window and runs the
//  three channel lanes; results sit in an output register. The lag compare
//  (one small multiply) and the line memory read port set the per-cycle work.
//  Back-pressure on m_axis stalls s_axis in the same cycle once the window
//  stage holds a result. Reset clears counters and window; the line memories
//  are not cleared.
// ----------------------------------------------------------------------------
module laplacian_edge_filter_3x3_unit
  import lef_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [7:0] red, [15:8] green, [23:16] blue
  input  logic        s_axis_tuser,   // command: 0 pixel, 1 flush

  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // red, green, blue, column[33:24], row[43:34]
  output logic        m_axis_tlast,   // frame_end

  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int RST_WIDTH  = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;
  localparam int RST_HEIGHT = (MAX_HEIGHT < 1024) ? MAX_HEIGHT : 1024;
  localparam int DR_W       = CMP_W + 1;
  localparam int DIFF_W     = 2 * DR_W + 1;

  typedef enum logic {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic             pix;
    logic             emit;
    logic             border;
    logic             last;
    logic [POS_W-1:0] col;
    logic [POS_W-1:0] row;
    logic [COL_W-1:0] addr;
    pixel_t           px;
  } wstage_t;

  // ---------------------------------------------------------------- config
  logic [SIZE_W-1:0] width_q, height_q;
  logic [SIZE_W-1:0] wr_val;
  logic              cfg_wr;
  reg_idx_e          cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = reg_idx_e'(paddr[2]);
  assign wr_val  = pwdata[SIZE_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= SIZE_W'(RST_WIDTH);
      height_q <= SIZE_W'(RST_HEIGHT);
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_WIDTH: begin
          if (wr_val == '0) begin
            width_q <= SIZE_W'(1);
          end else if (CMP_W'(wr_val) > CMP_W'(MAX_WIDTH)) begin
            width_q <= SIZE_W'(MAX_WIDTH);
          end else begin
            width_q <= wr_val;
          end
        end
        REG_HEIGHT: begin
          if (wr_val == '0) begin
            height_q <= SIZE_W'(1);
          end else if (CMP_W'(wr_val) > CMP_W'(MAX_HEIGHT)) begin
            height_q <= SIZE_W'(MAX_HEIGHT);
          end else begin
            height_q <= wr_val;
          end
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_WIDTH:  prdata = 32'(width_q);
      REG_HEIGHT: prdata = 32'(height_q);
      default:    prdata = '0;
    endcase
  end

  // ---------------------------------------------------------- accept stage
  logic [COL_W-1:0] in_col_q, in_col_d, out_col_q, out_col_d;
  logic [ROW_W-1:0] in_row_q, in_row_d, out_row_q, out_row_d;
  logic             lag_q, lag_d;

  logic                     accept, is_flush, emit_a;
  logic                     oc_end, or_end, ic_end, ir_end;
  logic                     border_a, last_a;
  logic signed [DR_W-1:0]   dr, dc, w_s;
  logic signed [DIFF_W-1:0] diff;
  logic                     wst_fire, out_free;
  logic                     wst_load;
  wstage_t                  wst_q, wst_d;
  logic                     wst_valid_q;

  assign accept   = s_axis_tvalid & s_axis_tready;
  assign is_flush = s_axis_tuser;

  assign oc_end = (CMP_W'(out_col_q) + CMP_W'(1)) >= CMP_W'(width_q);
  assign or_end = (CMP_W'(out_row_q) + CMP_W'(1)) >= CMP_W'(height_q);
  assign ic_end = (CMP_W'(in_col_q) + CMP_W'(1)) >= CMP_W'(width_q);
  assign ir_end = (CMP_W'(in_row_q) + CMP_W'(1)) >= CMP_W'(height_q);

  assign border_a = (out_row_q == '0) || (out_col_q == '0) || or_end || oc_end;
  assign last_a   = or_end && oc_end;

  // input ahead of output by more than a row: (ir-or-1)*W + (ic-oc) > 0
  assign dr   = $signed(DR_W'(in_row_q)) - $signed(DR_W'(out_row_q)) - $signed(DR_W'(1));
  assign dc   = $signed(DR_W'(in_col_q)) - $signed(DR_W'(out_col_q));
  assign w_s  = $signed(DR_W'(width_q));
  assign diff = (dr * w_s) + DIFF_W'(dc);

  assign emit_a = lag_q || (!is_flush && (diff > 0));

  always_comb begin
    in_col_d  = in_col_q;
    in_row_d  = in_row_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    lag_d     = lag_q;
    if (accept && emit_a) begin
      if (oc_end) begin
        out_col_d = '0;
        if (or_end) begin
          out_row_d = '0;
          lag_d     = 1'b0;
        end else begin
          out_row_d = out_row_q + ROW_W'(1);
        end
      end else begin
        out_col_d = out_col_q + COL_W'(1);
      end
    end
    if (accept && !is_flush) begin
      if (ic_end) begin
        in_col_d = '0;
        if (ir_end) begin
          in_row_d = '0;
          // overrun: drop what is left of the earlier frame
          if (lag_d) begin
            out_col_d = '0;
            out_row_d = '0;
          end
          lag_d = 1'b1;
        end else begin
          in_row_d = in_row_q + ROW_W'(1);
        end
      end else begin
        in_col_d = in_col_q + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
      lag_q     <= 1'b0;
    end else begin
      in_col_q  <= in_col_d;
      in_row_q  <= in_row_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
      lag_q     <= lag_d;
    end
  end

  // a flush with nothing pending is consumed here
  assign wst_load = accept && (!is_flush || lag_q);

  always_comb begin
    wst_d.pix    = !is_flush;
    wst_d.emit   = emit_a;
    wst_d.border = border_a;
    wst_d.last   = last_a;
    wst_d.col    = POS_W'(out_col_q);
    wst_d.row    = POS_W'(out_row_q);
    wst_d.addr   = in_col_q;
    wst_d.px     = s_axis_tdata;
  end

  // ------------------------------------------------------------ line store
  ls_ctrl_t ls_ctrl;
  pixel_t   top_rd, mid_rd;

  assign ls_ctrl.rd_en    = accept && !is_flush;
  assign ls_ctrl.rd_addr  = in_col_q;
  assign ls_ctrl.wr0_en   = wst_fire && wst_q.pix;
  assign ls_ctrl.wr0_addr = wst_q.addr;

  lef_line_store u_line_store (
    .clk_i  (clk_i),
    .ctrl_i (ls_ctrl),
    .px_i   (s_axis_tdata),
    .top_o  (top_rd),
    .mid_o  (mid_rd)
  );

  // ---------------------------------------------------------- window stage
  pixel_t [2:0][2:0] win_q, win_shift, win_sel;
  logic   [NCHAN-1:0][CHAN_W-1:0] lane_edge;

  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign wst_fire      = wst_valid_q && (!wst_q.emit || out_free);
  assign s_axis_tready = !wst_valid_q || wst_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wst_valid_q <= 1'b0;
    end else if (wst_load) begin
      wst_valid_q <= 1'b1;
    end else if (wst_fire) begin
      wst_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wst_load) begin
      wst_q <= wst_d;
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_shift[r][0] = win_q[r][1];
      win_shift[r][1] = win_q[r][2];
    end
    win_shift[0][2] = top_rd;
    win_shift[1][2] = mid_rd;
    win_shift[2][2] = wst_q.px;
    win_sel = wst_q.pix ? win_shift : win_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else if (wst_fire && wst_q.pix) begin
      win_q <= win_shift;
    end
  end

  for (genvar ch = 0; ch < NCHAN; ch++) begin : g_lane
    lane_win_t lane_win;

    always_comb begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          lane_win[r*3+c] = win_sel[r][c][ch];
        end
      end
    end

    lef_lane u_lane (
      .win_i  (lane_win),
      .edge_o (lane_edge[ch])
    );
  end

  // ----------------------------------------------------------- merge/output
  logic             res_valid_q;
  pixel_t           res_px_q;
  logic [POS_W-1:0] res_col_q, res_row_q;
  logic             res_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (wst_fire && wst_q.emit) begin
      res_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wst_fire && wst_q.emit) begin
      res_px_q   <= wst_q.border ? '0 : lane_edge;
      res_col_q  <= wst_q.col;
      res_row_q  <= wst_q.row;
      res_last_q <= wst_q.last;
    end
  end

  assign m_axis_tvalid = res_valid_q;
  assign m_axis_tdata  = {4'b0000, res_row_q, res_col_q, res_px_q};
  assign m_axis_tlast  = res_last_q;

  // ------------------------------------------------------------ assertions
  a_emit_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wst_fire && wst_q.emit |=> m_axis_tvalid)
    else $error("result left window stage without reaching output");

  a_flush_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && is_flush && lag_q |=> wst_valid_q && wst_q.emit)
    else $error("pending flush was dropped");

  a_last_is_border: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[23:0] == 24'd0)
    else $error("frame end pixel carries nonzero edge value");

  a_no_stall_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wst_valid_q && wst_q.emit && m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input taken while window stage is blocked");

endmodule

>>> test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the 3x3 Laplacian edge filter. A transfer-level
// shadow of the filter (line stores, window, counters, lag tracking) predicts
// every output transfer. The checker compares each m_axis transfer field by
// field, in order. Stimulus covers value extremes, size register saturation,
// tiny frame sizes, flushes, overrun and mid-frame resizing, and long output
// stalls, followed by randomized frame streams.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import lef_pkg::*;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int RANDOM_ITEMS  = 250;
  localparam int QUIET_TAIL    = 60;
  localparam int HOLD_CYCLES   = 60;
  localparam int SETTLE_CYCLES = 4;
  // widest frame the random stream picks; line store columns below it get written early
  localparam int RAND_WIDE     = 40;

  localparam logic [2:0] WIDTH_ADDR  = 3'h0;
  localparam logic [2:0] HEIGHT_ADDR = 3'h4;

  localparam bit CMD_PIXEL = 1'b0;
  localparam bit CMD_FLUSH = 1'b1;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [9:0] column;
    logic [9:0] row;
    logic       frame_end;
  } edge_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;   // [7:0] red, [15:8] green, [23:16] blue
  logic        s_axis_tuser;   // command: 0 pixel, 1 flush
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;   // [7:0] red, [15:8] green, [23:16] blue,
                               // [33:24] column, [43:34] row
  logic        m_axis_tlast;   // frame_end
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  laplacian_edge_filter_3x3_unit dut (.*);

  // shadow filter state
  pixel_t      line_top [MAX_WIDTH] = '{default: '0};
  pixel_t      line_mid [MAX_WIDTH] = '{default: '0};
  pixel_t      win [3][3]           = '{default: '0};
  int unsigned in_col = 0, in_row = 0, out_col = 0, out_row = 0;
  int unsigned frame_w = MAX_WIDTH, frame_h = MAX_HEIGHT;
  bit          lagging = 1'b0;
  edge_result_t edge_results_due [$];

  bit          src_idle_on    = 1'b0;
  bit          sink_idle_on   = 1'b0;
  bit          stray_flush_on = 1'b0;
  bit          hold_output    = 1'b0;
  int unsigned error_count = 0, pixel_count = 0, flush_count = 0;
  int unsigned result_count = 0, frame_end_count = 0, size_settings = 0;
  int unsigned active_items = 0;
  int unsigned cycle_count = 0;

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endfunction

  function automatic int unsigned clamp_size(logic [31:0] raw, int unsigned maxv);
    int unsigned v;
    v = raw & 32'h7FF;
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  function automatic logic [7:0] lane_strength(int ch);
    int acc;
    acc = 8 * int'(win[1][1][ch]);
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++)
        if (r != 1 || c != 1) acc -= int'(win[r][c][ch]);
    if (acc < 0) return 8'd0;
    if (acc > 255) return 8'd255;
    return 8'(acc);
  endfunction

  function automatic void emit_result();
    edge_result_t res;
    bit border, last;
    border = out_row == 0 || out_col == 0 ||
             out_row + 1 >= frame_h || out_col + 1 >= frame_w;
    last   = out_row + 1 >= frame_h && out_col + 1 >= frame_w;
    res.red       = border ? 8'd0 : lane_strength(0);
    res.green     = border ? 8'd0 : lane_strength(1);
    res.blue      = border ? 8'd0 : lane_strength(2);
    res.column    = 10'(out_col);
    res.row       = 10'(out_row);
    res.frame_end = last;
    edge_results_due.push_back(res);
    if (out_col + 1 >= frame_w) begin
      out_col = 0;
      if (out_row + 1 >= frame_h) begin
        out_row = 0;
        lagging = 1'b0;
      end else begin
        out_row++;
      end
    end else begin
      out_col++;
    end
  endfunction

  // returns 1 when the transfer produced a result
  function automatic bit step_filter(bit flush, pixel_t px);
    pixel_t top, mid;
    bit produced;
    logic [COL_W-1:0] col;
    if (flush) begin
      if (!lagging) return 1'b0;
      emit_result();
      return 1'b1;
    end
    produced = 1'b0;
    col = COL_W'(in_col);
    top = line_top[col];
    mid = line_mid[col];
    line_top[col] = mid;
    line_mid[col] = px;
    for (int r = 0; r < 3; r++) begin
      win[r][0] = win[r][1];
      win[r][1] = win[r][2];
    end
    win[0][2] = top;
    win[1][2] = mid;
    win[2][2] = px;
    if (lagging) begin
      emit_result();
      produced = 1'b1;
    end else if (longint'(in_row) * frame_w + in_col >=
                 longint'(out_row) * frame_w + out_col + frame_w + 1) begin
      emit_result();
      produced = 1'b1;
    end
    if (in_col + 1 >= frame_w) begin
      in_col = 0;
      if (in_row + 1 >= frame_h) begin
        in_row = 0;
        if (lagging) begin
          // earlier frame still pending: its remaining results are dropped
          out_col = 0;
          out_row = 0;
        end
        lagging = 1'b1;
      end else begin
        in_row++;
      end
    end else begin
      in_col++;
    end
    return produced;
  endfunction

  function automatic pixel_t random_pixel();
    pixel_t px;
    for (int ch = 0; ch < NCHAN; ch++) begin
      case ($urandom_range(0, 9))
        0:       px[ch] = 8'h00;
        1:       px[ch] = 8'hFF;
        default: px[ch] = 8'($urandom);
      endcase
    end
    return px;
  endfunction

  function automatic logic [31:0] pick_dim(int unsigned hi_common, int unsigned hi_rare);
    case ($urandom_range(0, 19))
      0:       return 32'd0;
      1:       return 32'd1;
      2:       return $urandom_range(hi_common + 1, hi_rare);
      3:       return $urandom_range(2, hi_common) | ($urandom & 32'hFFFF_F800);
      default: return $urandom_range(2, hi_common);
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // bus helpers; all start and end at a falling edge
  // --------------------------------------------------------------------------
  task automatic send_item(input bit flush, input pixel_t px);
    bit produced;
    if (src_idle_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= px;
    s_axis_tuser  <= flush;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    produced = step_filter(flush, px);
    if (flush) flush_count++;
    else pixel_count++;
    if (!flush || produced) active_items++;
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (edge_results_due.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic apb_access(input bit is_write, input logic [2:0] addr,
                            input logic [31:0] wdata, output logic [31:0] rdata);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= is_write;
    paddr   <= addr;
    pwdata  <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rdata = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic check_size_regs();
    logic [31:0] value;
    apb_access(1'b0, WIDTH_ADDR, '0, value);
    check_field("frame_width register", frame_w, value);
    apb_access(1'b0, HEIGHT_ADDR, '0, value);
    check_field("frame_height register", frame_h, value);
  endtask

  task automatic set_frame_size(input logic [31:0] raw_w, input logic [31:0] raw_h);
    logic [31:0] ignored_rd;
    wait_drained();
    apb_access(1'b1, WIDTH_ADDR, raw_w, ignored_rd);
    frame_w = clamp_size(raw_w, MAX_WIDTH);
    apb_access(1'b1, HEIGHT_ADDR, raw_h, ignored_rd);
    frame_h = clamp_size(raw_h, MAX_HEIGHT);
    check_size_regs();
    size_settings++;
  endtask

  // send pixels until the input position wraps to the frame start
  task automatic finish_frame();
    do begin
      if (stray_flush_on && $urandom_range(0, 23) == 0)
        send_item(CMD_FLUSH, random_pixel());
      send_item(CMD_PIXEL, random_pixel());
    end while (in_col != 0 || in_row != 0);
  endtask

  task automatic drain_frame();
    while (lagging) send_item(CMD_FLUSH, random_pixel());
  endtask

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------
  task automatic test_register_defaults();
    check_size_regs();
  endtask

  // 4x4 frame: saturation high and low, exact 255, flush before any lag
  task automatic test_value_extremes();
    pixel_t px;
    int r, c;
    set_frame_size(4, 4);
    for (int i = 0; i < 16; i++) begin
      r = i / 4;
      c = i % 4;
      px[0] = (r == 1 && c == 1) ? 8'hFF : 8'h00;
      px[1] = (r == 2 && c == 2) ? 8'h00 : 8'hFF;
      px[2] = 8'(3 * i * i);
      if (i == 6) send_item(CMD_FLUSH, '1);
      send_item(CMD_PIXEL, px);
    end
    drain_frame();
    send_item(CMD_FLUSH, '0);
  endtask

  // size registers saturate; then the widest random frame, which leaves
  // every line store column the later tests touch written
  task automatic test_wide_frame();
    set_frame_size(32'h0000_07FF, 32'h0000_07FF);
    set_frame_size(RAND_WIDE, 3);
    finish_frame();
    drain_frame();
  endtask

  task automatic test_tall_frame();
    set_frame_size(3, RAND_WIDE);
    finish_frame();
    drain_frame();
  endtask

  // one-pixel frames and other degenerate sizes, frames drained by the next one
  task automatic test_tiny_frames();
    logic [31:0] widths [4]  = '{32'd0, 32'd2, 32'd1, 32'd3};
    logic [31:0] heights [4] = '{32'hFFFF_F800, 32'd1, 32'd3, 32'd2};
    for (int k = 0; k < 4; k++) begin
      set_frame_size(widths[k], heights[k]);
      repeat (3) finish_frame();
      drain_frame();
      send_item(CMD_FLUSH, random_pixel());
    end
  endtask

  // next frame ends while the earlier one is still pending
  task automatic test_frame_overrun();
    set_frame_size(4, 3);
    finish_frame();
    send_item(CMD_PIXEL, random_pixel());
    set_frame_size(4, 1);
    finish_frame();
    drain_frame();
    send_item(CMD_FLUSH, random_pixel());
  endtask

  task automatic test_resize_mid_frame();
    set_frame_size(5, 5);
    repeat (13) send_item(CMD_PIXEL, random_pixel());
    set_frame_size(3, 3);
    finish_frame();
    drain_frame();
    set_frame_size(6, 4);
    repeat (8) send_item(CMD_PIXEL, random_pixel());
    set_frame_size(9, 5);
    finish_frame();
    drain_frame();
  endtask

  task automatic test_output_stall();
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b0;
    set_frame_size(8, 6);
    hold_output = 1'b1;
    finish_frame();
    drain_frame();
    wait_drained();
  endtask

  task automatic test_random_stream();
    int unsigned start, cut;
    start = active_items;
    src_idle_on    = 1'b1;
    sink_idle_on   = 1'b1;
    stray_flush_on = 1'b1;
    while (active_items - start < RANDOM_ITEMS) begin
      if (active_items - start >= RANDOM_ITEMS - QUIET_TAIL) begin
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
      end
      if ($urandom_range(0, 3) == 0)
        set_frame_size(pick_dim(12, RAND_WIDE), pick_dim(8, 16));
      // broken frame: cut short, resized, then completed
      if ($urandom_range(0, 7) == 0) begin
        cut = $urandom_range(1, frame_w * frame_h);
        repeat (cut) send_item(CMD_PIXEL, random_pixel());
        set_frame_size(pick_dim(12, RAND_WIDE), pick_dim(8, 16));
      end
      finish_frame();
      case ($urandom_range(0, 9))
        0, 1, 2, 3: ;
        4, 5, 6, 7: drain_frame();
        default:    repeat ($urandom_range(1, frame_w)) send_item(CMD_FLUSH, random_pixel());
      endcase
      if ($urandom_range(0, 5) == 0) send_item(CMD_FLUSH, random_pixel());
    end
    drain_frame();
  endtask

  // --------------------------------------------------------------------------
  // clock, output ready, checker, watchdog
  // --------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin : output_ready
    int burst;
    burst = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_output) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_output = 1'b0;
      end else if (burst > 0) begin
        burst--;
        m_axis_tready <= 1'b0;
      end else if (sink_idle_on && $urandom_range(0, 4) == 0) begin
        burst = $urandom_range(0, 5);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    edge_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      result_count++;
      if (m_axis_tlast === 1'b1) frame_end_count++;
      if (edge_results_due.size() == 0) begin
        $error("unexpected result transfer at row %0d column %0d",
               m_axis_tdata[43:34], m_axis_tdata[33:24]);
        error_count++;
      end else begin
        want = edge_results_due.pop_front();
        check_field("red", 32'(want.red), 32'(m_axis_tdata[7:0]));
        check_field("green", 32'(want.green), 32'(m_axis_tdata[15:8]));
        check_field("blue", 32'(want.blue), 32'(m_axis_tdata[23:16]));
        check_field("column", 32'(want.column), 32'(m_axis_tdata[33:24]));
        check_field("row", 32'(want.row), 32'(m_axis_tdata[43:34]));
        check_field("frame_end", 32'(want.frame_end), 32'(m_axis_tlast));
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results outstanding",
             cycle_count, edge_results_due.size());
    $display("Some tests failed");
    $finish;
  end

  initial begin : run
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_register_defaults();
    test_value_extremes();
    test_wide_frame();
    test_tall_frame();
    test_tiny_frames();
    test_frame_overrun();
    test_resize_mid_frame();
    test_output_stall();
    test_random_stream();
    wait_drained();

    $display("Covered %0d pixel and %0d flush transfers over %0d frame size settings,",
             pixel_count, flush_count, size_settings);
    $display("with %0d filtered pixels checked and %0d frame ends seen.",
             result_count, frame_end_count);
    if (error_count == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule

>>> sim.f
rtl/lef_pkg.sv
rtl/lef_line_store.sv
rtl/lef_lane.sv
rtl/laplacian_edge_filter_3x3_unit.sv
test/testbench.sv
